// ----- hw/rtl/nmc_pkg.sv -----
package nmc_pkg;

    // Grid geometry and register field widths.
    localparam int MAX_COLS_DEF = 32;
    localparam int ROWS_W       = 16;
    localparam int COLS_W       = 6;
    localparam int CHAR_W       = 8;
    localparam int COUNT_W      = 4;
    localparam int COLSUM_W     = 2;

    // Each column word holds the two previous rows: bit 0 the newer, bit 1 the older.
    localparam int MEM_W = 2;

    // Byte that marks a mine.
    localparam logic [CHAR_W-1:0] MARK_BYTE = 8'h21;

    // Largest possible window count.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd9;

    // Register reset values.
    localparam logic [ROWS_W-1:0] ROWS_RST = 16'd16;
    localparam logic [COLS_W-1:0] COLS_RST = 6'd32;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register index, taken from the word address.
    typedef enum logic [0:0] {
        REG_NUM_ROWS = 1'b0,
        REG_NUM_COLS = 1'b1
    } t_reg_idx;

    // Result queue.
    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_AW    = $clog2(OBUF_DEPTH);
    localparam int OBUF_CW    = $clog2(OBUF_DEPTH + 1);

    // Control for one column step in the window stage.
    typedef struct packed {
        logic valid;
        logic mark;       // mark bit of the newest row at this column
        logic v1;         // row above the newest row lies in the frame
        logic v2;         // row two above the newest row lies in the frame
        logic emit_a;     // give the result for the column to the left
        logic emit_b;     // give the result for this column (last column)
        logic first;      // column zero: left padding
        logic wr;         // write the column word back
        logic frame_end;  // this step gives the frame's last result
        logic last_run;   // this step gives the final result of its run
    } t_stage;

    // One result beat.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               last;
        logic               done;
    } t_result;

endpackage

// ----- hw/rtl/nmc_ram.sv -----
module nmc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; a read of the entry being
    // written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/nmc_seq.sv -----
module nmc_seq import nmc_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF,
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_restart,
    input  logic [COLS_W-1:0]  i_eff_cols,
    input  logic [ROWS_W-1:0]  i_eff_rows,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CHAR_W-1:0]  i_cell_char,
    input  logic [OBUF_CW-1:0] i_obuf_cnt,
    output logic [CW-1:0]      o_rd_addr,
    output t_stage             o_s1,
    output logic [CW-1:0]      o_s1_col
);

    logic [CW-1:0]     r_col, n_col;
    logic [CW-1:0]     r_fcol, n_fcol;
    logic [ROWS_W-1:0] r_row, n_row;
    logic              r_flush, n_flush;
    logic              r_flush_v2, n_flush_v2;
    t_stage            r_s1, n_s1;
    logic [CW-1:0]     r_s1_col, n_s1_col;

    logic              row_ge1;
    logic              row_ge2;
    logic              last_col;
    logic              last_row;
    logic              last_cell;
    logic              flush_last;
    logic [1:0]        s1_results;
    logic              credit_ok;
    logic              in_go;
    logic              flush_go;

    // Position decode.
    assign row_ge1    = (r_row != '0);
    assign row_ge2    = |r_row[ROWS_W-1:1];
    assign last_col   = (COLS_W'(r_col) == (i_eff_cols - COLS_W'(1)));
    assign last_row   = (r_row == (i_eff_rows - ROWS_W'(1)));
    assign last_cell  = last_col && last_row;
    assign flush_last = (COLS_W'(r_fcol) == (i_eff_cols - COLS_W'(1)));

    // A step may start only if the queue can take both results of the step
    // in the window stage and up to two of the new one.
    assign s1_results = r_s1.valid ? ({1'b0, r_s1.emit_a} + {1'b0, r_s1.emit_b}) : 2'd0;
    assign credit_ok  = ((OBUF_CW + 1)'(i_obuf_cnt) + (OBUF_CW + 1)'(s1_results)
                         + (OBUF_CW + 1)'(2)) <= (OBUF_CW + 1)'(OBUF_DEPTH);

    assign o_in_stall = r_flush || !credit_ok;
    assign in_go      = i_in_valid && !o_in_stall;
    assign flush_go   = r_flush && credit_ok;

    // The column word is read in the cycle the step starts.
    assign o_rd_addr = r_flush ? r_fcol : r_col;

    // Next position, flush sweep and window stage control.
    always_comb begin
        n_col      = r_col;
        n_fcol     = r_fcol;
        n_row      = r_row;
        n_flush    = r_flush;
        n_flush_v2 = r_flush_v2;
        n_s1       = '0;
        n_s1_col   = o_rd_addr;

        if (in_go) begin
            n_s1.valid     = 1'b1;
            n_s1.mark      = (i_cell_char == MARK_BYTE);
            n_s1.v1        = row_ge1;
            n_s1.v2        = row_ge2;
            n_s1.emit_a    = row_ge1 && (r_col != '0);
            n_s1.emit_b    = row_ge1 && last_col;
            n_s1.first     = (r_col == '0);
            n_s1.wr        = 1'b1;
            n_s1.last_run  = !last_cell;
            if (last_col) begin
                n_col = '0;
                n_row = last_cell ? '0 : (r_row + ROWS_W'(1));
            end else begin
                n_col = r_col + CW'(1);
            end
            if (last_cell) begin
                n_flush    = 1'b1;
                n_fcol     = '0;
                n_flush_v2 = row_ge1;
            end
        end else if (flush_go) begin
            // The final row sees an empty row below it.
            n_s1.valid     = 1'b1;
            n_s1.v1        = 1'b1;
            n_s1.v2        = r_flush_v2;
            n_s1.emit_a    = (r_fcol != '0);
            n_s1.emit_b    = flush_last;
            n_s1.first     = (r_fcol == '0);
            n_s1.frame_end = flush_last;
            n_s1.last_run  = flush_last;
            if (flush_last) begin
                n_flush = 1'b0;
            end else begin
                n_fcol = r_fcol + CW'(1);
            end
        end

        if (i_restart) begin
            n_col   = '0;
            n_row   = '0;
            n_flush = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_fcol     <= '0;
            r_row      <= '0;
            r_flush    <= 1'b0;
            r_flush_v2 <= 1'b0;
            r_s1       <= '0;
        end else begin
            r_col      <= n_col;
            r_fcol     <= n_fcol;
            r_row      <= n_row;
            r_flush    <= n_flush;
            r_flush_v2 <= n_flush_v2;
            r_s1       <= n_s1;
        end
        r_s1_col <= n_s1_col;
    end

    assign o_s1     = r_s1;
    assign o_s1_col = r_s1_col;

endmodule

// ----- hw/rtl/nmc_win.sv -----
module nmc_win import nmc_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF,
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_stage           i_s1,
    input  logic [CW-1:0]    i_s1_col,
    input  logic [CW-1:0]    i_rd_addr,
    input  logic [MEM_W-1:0] i_rd_data,
    output logic             o_we,
    output logic [CW-1:0]    o_waddr,
    output logic [MEM_W-1:0] o_wdata,
    output logic [1:0]       o_push_n,
    output t_result          o_res0,
    output t_result          o_res1
);

    logic                r_fwd_hit;
    logic [MEM_W-1:0]    r_fwd_data;
    logic [COLSUM_W-1:0] r_p1, n_p1;
    logic [COLSUM_W-1:0] r_p2, n_p2;

    logic [MEM_W-1:0]    word;
    logic [COLSUM_W-1:0] cur;
    t_result             res_a;
    t_result             res_b;
    logic                both;

    // A write and a read of the same column in one cycle: the RAM returns
    // the old word, so the written word is forwarded.
    assign word = r_fwd_hit ? r_fwd_data : i_rd_data;

    // Column sum over the three rows of the window.
    assign cur = COLSUM_W'(i_s1.mark) + COLSUM_W'(word[0] && i_s1.v1)
               + COLSUM_W'(word[1] && i_s1.v2);

    // Shift the rows down by one: the newest row becomes the newer one.
    assign o_we    = i_s1.valid && i_s1.wr;
    assign o_waddr = i_s1_col;
    assign o_wdata = {word[0], i_s1.mark};

    // Window counts: left column, middle column, this column.
    always_comb begin
        res_a       = '0;
        res_b       = '0;
        res_a.count = COUNT_W'(r_p2) + COUNT_W'(r_p1) + COUNT_W'(cur);
        res_b.count = (i_s1.first ? COUNT_W'(0) : COUNT_W'(r_p1)) + COUNT_W'(cur);
        res_b.done  = i_s1.frame_end;
        both        = i_s1.emit_a && i_s1.emit_b;
        res_a.last  = i_s1.last_run && !i_s1.emit_b;
        res_b.last  = i_s1.last_run;
    end

    // The first beat is the left result when there is one.
    always_comb begin
        o_push_n = '0;
        o_res0   = res_b;
        o_res1   = res_b;
        if (i_s1.valid) begin
            o_push_n = {1'b0, i_s1.emit_a} + {1'b0, i_s1.emit_b};
            if (i_s1.emit_a) begin
                o_res0 = res_a;
            end
        end
        if (!both) begin
            o_res1 = res_b;
        end
    end

    // Column sums of the two columns to the left; zero left of column zero.
    always_comb begin
        n_p1 = r_p1;
        n_p2 = r_p2;
        if (i_s1.valid) begin
            n_p1 = cur;
            n_p2 = i_s1.first ? '0 : r_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= o_we && (o_waddr == i_rd_addr);
        end
        r_fwd_data <= o_wdata;
        r_p1       <= n_p1;
        r_p2       <= n_p2;
    end

endmodule

// ----- hw/rtl/nmc_obuf.sv -----
module nmc_obuf import nmc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_push_n,
    input  t_result            i_res0,
    input  t_result            i_res1,
    output logic [OBUF_CW-1:0] o_cnt,
    output logic               o_valid,
    input  logic               i_stall,
    output t_result            o_res
);

    t_result            r_buf [OBUF_DEPTH];
    logic [OBUF_AW-1:0] r_wp, n_wp;
    logic [OBUF_AW-1:0] r_rp, n_rp;
    logic [OBUF_CW-1:0] r_cnt, n_cnt;
    logic               pop;
    logic [OBUF_AW-1:0] wp_next;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_buf[r_rp];
    assign o_cnt   = r_cnt;
    assign pop     = o_valid && !i_stall;
    assign wp_next = r_wp + OBUF_AW'(1);

    // Pointer and fill level update.
    always_comb begin
        n_wp  = r_wp + OBUF_AW'(i_push_n);
        n_rp  = pop ? (r_rp + OBUF_AW'(1)) : r_rp;
        n_cnt = r_cnt + OBUF_CW'(i_push_n) - OBUF_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Up to two beats enter per cycle.
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_buf[r_wp] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_buf[wp_next] <= i_res1;
        end
    end

endmodule

// ----- hw/rtl/neighbor_mine_count_3x3_top.sv -----
// Streaming 3x3 mine counter. Cells arrive in row-major order, one beat per
// cell, and each result beat carries the number (0 to 9) of '!' cells in
// the 3x3 window around one cell, with cells off the grid counted as empty.
// The result for a cell leaves once its lower-right neighbor has arrived, so
// results trail the input by one row and one column; the last cell of the
// frame then sweeps the final row out, and the frame's last beat has both
// o_last_of_run and o_frame_done set. A cell is taken every cycle while the
// result queue has room and no sweep runs; each one is one read and one
// write-back of a 2-bit column word in a single RAM of MAX_COLS entries; its
// results go through the window stage register into the result queue. The
// output port moves one beat a cycle when not stalled, so the two beats of a
// row's last column queue up, and the sweep holds the input off. Writing
// either register restarts the frame at row 0, column 0; num_rows = 0 and
// num_cols = 0 act as 1, and num_cols above MAX_COLS acts as MAX_COLS.
module neighbor_mine_count_3x3_top import nmc_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF,
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CHAR_W-1:0]  i_cell_char,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [COUNT_W-1:0] o_mine_count,
    output logic               o_last_of_run,
    output logic               o_frame_done
);

    logic [ROWS_W-1:0]  r_num_rows;
    logic [COLS_W-1:0]  r_num_cols;
    logic               cfg_wr;
    t_reg_idx           reg_idx;
    logic [COLS_W-1:0]  eff_cols;
    logic [ROWS_W-1:0]  eff_rows;

    logic [OBUF_CW-1:0] obuf_cnt;
    logic [CW-1:0]      rd_addr;
    logic [MEM_W-1:0]   rd_data;
    t_stage             s1;
    logic [CW-1:0]      s1_col;
    logic               mem_we;
    logic [CW-1:0]      mem_waddr;
    logic [MEM_W-1:0]   mem_wdata;
    logic [1:0]         push_n;
    t_result            res0;
    t_result            res1;
    t_result            res_out;

    // Configuration registers.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= ROWS_RST;
            r_num_cols <= COLS_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_NUM_ROWS: r_num_rows <= pwdata[ROWS_W-1:0];
                REG_NUM_COLS: r_num_cols <= pwdata[COLS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_NUM_ROWS: prdata = APB_DW'(r_num_rows);
            REG_NUM_COLS: prdata = APB_DW'(r_num_cols);
            default:      prdata = '0;
        endcase
    end

    // Effective grid size.
    always_comb begin
        if (r_num_cols == '0) begin
            eff_cols = COLS_W'(1);
        end else if (r_num_cols > COLS_W'(MAX_COLS)) begin
            eff_cols = COLS_W'(MAX_COLS);
        end else begin
            eff_cols = r_num_cols;
        end
        eff_rows = (r_num_rows == '0) ? ROWS_W'(1) : r_num_rows;
    end

    // Position tracking and step issue.
    nmc_seq #(
        .MAX_COLS (MAX_COLS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (cfg_wr),
        .i_eff_cols  (eff_cols),
        .i_eff_rows  (eff_rows),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cell_char (i_cell_char),
        .i_obuf_cnt  (obuf_cnt),
        .o_rd_addr   (rd_addr),
        .o_s1        (s1),
        .o_s1_col    (s1_col)
    );

    // Column store: the two rows above the one now arriving.
    nmc_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_COLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Column sums and window counts.
    nmc_win #(
        .MAX_COLS (MAX_COLS)
    ) u_win (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1      (s1),
        .i_s1_col  (s1_col),
        .i_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_we      (mem_we),
        .o_waddr   (mem_waddr),
        .o_wdata   (mem_wdata),
        .o_push_n  (push_n),
        .o_res0    (res0),
        .o_res1    (res1)
    );

    // Result queue in front of the output port.
    nmc_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_res0   (res0),
        .i_res1   (res1),
        .o_cnt    (obuf_cnt),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_res    (res_out)
    );

    assign o_mine_count  = res_out.count;
    assign o_last_of_run = res_out.last;
    assign o_frame_done  = res_out.done;

`ifndef SYNTHESIS
    // The frame's last beat always closes its run.
    a_done_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_last_of_run)
        else $error("frame end beat without last_of_run");

    // A window holds at most nine cells.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_mine_count <= COUNT_MAX))
        else $error("mine count above nine");

    // Issue credit keeps the result queue from overflowing.
    a_obuf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        obuf_cnt <= OBUF_CW'(OBUF_DEPTH))
        else $error("result queue overflow");
`endif

endmodule
